// File: rtl/core/svf_pkg.sv
// Shared types and constants for the resonant state variable low-pass filter.
`default_nettype none

package svf_pkg;

  localparam int SAMPLE_RATE_HZ = 44100;

  localparam int X_W     = 24;
  localparam int RATIO_W = 16;
  localparam int OUT_W   = 23;
  localparam int BASE_W  = 15;
  localparam int RES_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CUT_W  = 31;
  localparam int F_W    = 24;
  localparam int HP_W   = 25;
  localparam int BPN_W  = 27;
  localparam int LPN_W  = 28;
  localparam int DAMP_W = 17;
  localparam int PROD_W = 64;

  localparam int RATE_W      = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int NUM_W       = RATE_W + F_W;
  // quotient estimate from the top bits of the numerator times a reciprocal,
  // low by at most one, then fixed with one compare
  localparam int NUM_TOP_W   = 31;
  localparam int RECIP_SHIFT = 33;

  localparam longint CUT_MAX_L = (longint'(SAMPLE_RATE_HZ) * 64'sd18432) / 64'sd5;
  localparam logic [CUT_W-1:0] CUTOFF_MAX = CUT_W'(CUT_MAX_L);
  localparam logic [CUT_W-1:0] CUTOFF_MIN = CUT_W'(163840);
  localparam logic [PROD_W-1:0] DIV_ROUND = PROD_W'(longint'(SAMPLE_RATE_HZ) <<< 18);
  localparam longint RECIP_L = (longint'(1) <<< (RECIP_SHIFT - NUM_TOP_W + NUM_W)) /
                               longint'(SAMPLE_RATE_HZ);
  localparam logic [31:0] RECIP = 32'(RECIP_L);
  localparam logic [31:0] RATE_OP = 32'(SAMPLE_RATE_HZ);
  localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(SAMPLE_RATE_HZ);
  localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
  localparam logic [F_W-1:0] F_MIN = F_W'(419);
  localparam logic [RES_W-1:0] RES_MAX = RES_W'(64225);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(440);
  localparam int STATE_LIMIT = 2621440;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    MUL_CUT,
    MUL_TWOPI,
    MUL_DAMP,
    MUL_RECIP,
    MUL_QRATE,
    MUL_HP,
    MUL_BP
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CUT,
    ST_CLAMP,
    ST_MUL_F,
    ST_LD_NUM,
    ST_MUL_RECIP,
    ST_MUL_Q,
    ST_FMIN,
    ST_MUL_HP,
    ST_BP,
    ST_MUL_BP,
    ST_COMMIT
  } svf_state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_cut;
    logic     ld_num;
    logic     ld_q;
    logic     ld_hp;
    logic     ld_f;
    logic     ld_bp;
    logic     commit;
  } svf_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/svf_datapath.sv
// Datapath: config registers, shared multiplier, cutoff scaling and filter states.
`default_nettype none

module svf_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire svf_pkg::svf_cmd_t                cmd,
  input  wire logic                             cfg_we,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [svf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic signed [svf_pkg::X_W-1:0]   sample_in,
  input  wire logic [svf_pkg::RATIO_W-1:0]      cutoff_ratio,
  output logic signed [svf_pkg::OUT_W-1:0]      lowpass_out
);
  import svf_pkg::*;

  logic [BASE_W-1:0]         base_freq;
  logic [RES_W-1:0]          resonance;
  logic signed [X_W-1:0]     x_reg;
  logic [RATIO_W-1:0]        ratio_reg;
  logic signed [PROD_W-1:0]  prod;
  logic [CUT_W-1:0]          cutoff;
  logic [NUM_W-1:0]          num;
  logic [F_W-1:0]            q_est;
  logic signed [HP_W-1:0]    hp;
  logic [F_W-1:0]            f_coef;
  logic signed [BPN_W-1:0]   bp_new;
  logic signed [X_W-1:0]     lp_state;
  logic signed [X_W-1:0]     bp_state;

  logic [DAMP_W-1:0]         damp;
  logic signed [31:0]        op_a;
  logic signed [31:0]        op_b;
  logic [PROD_W-1:0]         num_sum;
  logic [NUM_W-1:0]          num_full;
  logic [NUM_W-1:0]          rem_c;
  logic [F_W-1:0]            q_fix;
  logic signed [PROD_W-1:0]  damp_r;
  logic signed [PROD_W-1:0]  rnd22;
  logic signed [HP_W-1:0]    hp_next;
  logic signed [BPN_W-1:0]   bp_next;
  logic signed [LPN_W-1:0]   lp_next;
  logic signed [X_W-1:0]     bp_sat;
  logic signed [X_W-1:0]     lp_sat;
  logic [CUT_W-1:0]          cut_raw;

  function automatic logic signed [X_W-1:0] sat_state(input logic signed [LPN_W-1:0] v);
    logic signed [LPN_W-1:0] lim;
    lim = LPN_W'(STATE_LIMIT);
    if (v > lim) begin
      return X_W'(STATE_LIMIT);
    end else if (v < -lim) begin
      return X_W'(-STATE_LIMIT);
    end
    return v[X_W-1:0];
  endfunction

  assign damp = DAMP_W'(65536) - DAMP_W'((resonance > RES_MAX) ? RES_MAX : resonance);

  always_comb begin
    case (cmd.mul_sel)
      MUL_CUT: begin
        op_a = $signed({17'b0, base_freq});
        op_b = $signed({16'b0, ratio_reg});
      end
      MUL_TWOPI: begin
        op_a = $signed({1'b0, cutoff});
        op_b = $signed(TWO_PI_Q28);
      end
      MUL_DAMP: begin
        op_a = $signed({15'b0, damp});
        op_b = 32'(bp_state);
      end
      MUL_RECIP: begin
        op_a = $signed({1'b0, num[NUM_W-1 -: NUM_TOP_W]});
        op_b = $signed(RECIP);
      end
      MUL_QRATE: begin
        op_a = $signed({8'b0, prod[RECIP_SHIFT +: F_W]});
        op_b = $signed(RATE_OP);
      end
      MUL_HP: begin
        op_a = $signed({8'b0, f_coef});
        op_b = 32'(hp);
      end
      default: begin
        op_a = $signed({8'b0, f_coef});
        op_b = 32'(bp_new);
      end
    endcase
  end

  assign cut_raw  = prod[CUT_W-1:0];
  assign num_sum  = $unsigned(prod) + DIV_ROUND;
  assign num_full = num_sum[19 +: NUM_W];

  // remainder after the quotient estimate; one more rate means the estimate was low
  assign rem_c = num - prod[NUM_W-1:0];
  assign q_fix = q_est + F_W'(rem_c >= RATE_NUM);

  assign damp_r  = (prod + 64'sd32768) >>> 16;
  assign rnd22   = (prod + 64'sd2097152) >>> 22;
  assign hp_next = HP_W'(x_reg) - HP_W'(lp_state) - $signed(damp_r[HP_W-1:0]);
  assign bp_next = BPN_W'(bp_state) + $signed(rnd22[BPN_W-1:0]);
  assign lp_next = LPN_W'(lp_state) + $signed(rnd22[LPN_W-1:0]);
  assign bp_sat  = sat_state(LPN_W'(bp_new));
  assign lp_sat  = sat_state(lp_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_freq <= BASE_RESET;
      resonance <= '0;
      lp_state  <= '0;
      bp_state  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_FREQ: base_freq <= cfg_data[BASE_W-1:0];
          CFG_RESONANCE: resonance <= cfg_data[RES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        bp_state <= bp_sat;
        lp_state <= lp_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_reg     <= sample_in;
      ratio_reg <= cutoff_ratio;
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.ld_cut) begin
      if (cut_raw > CUTOFF_MAX) begin
        cutoff <= CUTOFF_MAX;
      end else if (cut_raw < CUTOFF_MIN) begin
        cutoff <= CUTOFF_MIN;
      end else begin
        cutoff <= cut_raw;
      end
    end
    if (cmd.ld_num) begin
      num <= num_full;
    end
    if (cmd.ld_q) begin
      q_est <= prod[RECIP_SHIFT +: F_W];
    end
    if (cmd.ld_hp) begin
      hp <= hp_next;
    end
    if (cmd.ld_f) begin
      f_coef <= (q_fix < F_MIN) ? F_MIN : q_fix;
    end
    if (cmd.ld_bp) begin
      bp_new <= bp_next;
    end
    if (cmd.commit) begin
      lowpass_out <= lp_sat[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/svf_ctrl.sv
// Controller: sequences one sample through the datapath and owns the handshakes.
`default_nettype none

module svf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output svf_pkg::svf_cmd_t      cmd
);
  import svf_pkg::*;

  svf_state_t             state;
  svf_state_t             state_next;
  logic                   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL_CUT;
      ST_MUL_CUT:   state_next = ST_CLAMP;
      ST_CLAMP:     state_next = ST_MUL_F;
      ST_MUL_F:     state_next = ST_LD_NUM;
      ST_LD_NUM:    state_next = ST_MUL_RECIP;
      ST_MUL_RECIP: state_next = ST_MUL_Q;
      ST_MUL_Q:     state_next = ST_FMIN;
      ST_FMIN:      state_next = ST_MUL_HP;
      ST_MUL_HP:    state_next = ST_BP;
      ST_BP:        state_next = ST_MUL_BP;
      ST_MUL_BP:    state_next = ST_COMMIT;
      ST_COMMIT:    if (slot_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_CUT;
    unique case (state)
      ST_IDLE:     cmd.load_in = in_valid;
      ST_MUL_CUT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CUT;
      end
      ST_CLAMP:    cmd.ld_cut = 1'b1;
      ST_MUL_F: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TWOPI;
      end
      ST_LD_NUM: begin
        cmd.ld_num  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DAMP;
      end
      ST_MUL_RECIP: begin
        cmd.ld_hp   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RECIP;
      end
      ST_MUL_Q: begin
        cmd.ld_q    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_QRATE;
      end
      ST_FMIN:     cmd.ld_f = 1'b1;
      ST_MUL_HP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HP;
      end
      ST_BP:       cmd.ld_bp = 1'b1;
      ST_MUL_BP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BP;
      end
      ST_COMMIT:   cmd.commit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/resonant_svf_lowpass_core.sv
// Top level of the resonant state variable low-pass filter core.
// One request at a time: the input stalls until the result of the last one is committed.
// Each request runs seven products in sequence on the one shared 32x32 multiplier;
// the sample rate divide is a reciprocal product plus a fixup.
// A waiting result holds the next request in its last step, not at the input.
// Reset: synchronous; clears both filter states, base frequency to 440, resonance to 0.
`default_nettype none

module resonant_svf_lowpass_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [svf_pkg::X_W-1:0]    sample_in,
  input  wire logic [svf_pkg::RATIO_W-1:0]       cutoff_ratio,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [svf_pkg::OUT_W-1:0]       lowpass_out,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [svf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import svf_pkg::*;

  svf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  svf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_in    (sample_in),
    .cutoff_ratio (cutoff_ratio),
    .lowpass_out  (lowpass_out)
  );

endmodule

`default_nettype wire

// File: rtl/core/svf_checker.sv
// Port-level checker for the filter core, bound to the top level.
`default_nettype none

module svf_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [svf_pkg::OUT_W-1:0]  lowpass_out
);
  import svf_pkg::*;

  // one request in flight: accepting one closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request is in flight");

  // results only come from a request that was being processed
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // outputs are saturated states
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lowpass_out <= OUT_W'(STATE_LIMIT) && lowpass_out >= -OUT_W'(STATE_LIMIT)))
    else $error("low-pass output beyond saturation limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(lowpass_out)))
    else $error("stalled result changed or dropped");

endmodule

bind resonant_svf_lowpass_core svf_checker u_svf_checker (.*);

`default_nettype wire

// File: test/resonant_svf_lowpass_core_tb.sv
// Self-checking testbench for the resonant state variable low-pass filter core.
`default_nettype none

module resonant_svf_lowpass_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svf_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [X_W-1:0] sample_in = '0;
  logic [RATIO_W-1:0] cutoff_ratio = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] lowpass_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // filter state and registers as the core should hold them
  logic [BASE_W-1:0] base_hz = BASE_RESET;
  logic [RES_W-1:0] res_q16 = '0;
  longint lp_acc = 0;
  longint bp_acc = 0;

  logic signed [OUT_W-1:0] lowpass_due[$];
  logic signed [OUT_W-1:0] lowpass_head;

  int errors = 0;
  int in_count = 0;
  int out_count = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int out_gap = 0;
  bit rush = 1'b0;

  resonant_svf_lowpass_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .cutoff_ratio(cutoff_ratio),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .lowpass_out(lowpass_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip_state(longint v);
    if (v > STATE_LIMIT) return STATE_LIMIT;
    if (v < -STATE_LIMIT) return -STATE_LIMIT;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] svf_lowpass(logic signed [X_W-1:0] x,
                                                           logic [RATIO_W-1:0] ratio);
    longint unsigned rate;
    longint unsigned cut;
    longint unsigned cut_top;
    longint unsigned coef;
    logic [RES_W-1:0] r;
    longint damp;
    longint hp;
    longint bp_n;
    longint lp_n;
    rate = SAMPLE_RATE_HZ;
    cut_top = (rate * 18432) / 5;
    cut = base_hz;
    cut = cut * ratio;
    if (cut > cut_top) cut = cut_top;
    if (cut < 163840) cut = 163840;
    coef = (cut * TWO_PI_Q28 + (rate << 18)) / (rate << 19);
    if (coef < 419) coef = 419;
    r = (res_q16 > RES_MAX) ? RES_MAX : res_q16;
    damp = 65536 - longint'(r);
    hp = longint'(x) - lp_acc - round_shift(damp * bp_acc, 16);
    bp_n = bp_acc + round_shift(longint'(coef) * hp, 22);
    lp_n = lp_acc + round_shift(longint'(coef) * bp_n, 22);
    bp_acc = clip_state(bp_n);
    lp_acc = clip_state(lp_n);
    return lp_acc[OUT_W-1:0];
  endfunction

  // result side: random stall after each accepted result, none while rushing
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      out_gap = rush ? 0 : $urandom_range(0, 13);
      stall_left <= out_gap;
      out_stall <= (out_gap > 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_count++;
      if (lowpass_due.size() == 0) begin
        $error("lowpass_out: expected no result, got %0d", lowpass_out);
        errors++;
      end else begin
        lowpass_head = lowpass_due.pop_front();
        if (lowpass_out !== lowpass_head) begin
          $error("lowpass_out: expected %0d, got %0d", lowpass_head, lowpass_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [X_W-1:0] x, logic [RATIO_W-1:0] ratio);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    cutoff_ratio <= ratio;
    do @(posedge clk); while (in_stall);
    lowpass_due.push_back(svf_lowpass(x, ratio));
    in_count++;
  endtask

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (lowpass_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE_FREQ: base_hz = val[BASE_W-1:0];
      CFG_RESONANCE: res_q16 = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic test_reset_state();
    send_sample(24'sd8388607, 16'd8192);
    send_sample(-24'sd8388608, 16'd8192);
    send_sample(24'sd0, 16'd0);
    send_sample(24'sd262144, 16'd65535);
    send_sample(-24'sd1, 16'd1);
    send_sample(24'sd1, 16'h8000);
  endtask

  task automatic test_cutoff_clamps();
    write_reg(CFG_BASE_FREQ, 16'd0);
    send_sample(24'sd4000000, 16'd65535);
    write_reg(CFG_BASE_FREQ, 16'd20000);
    send_sample(-24'sd4000000, 16'd65535);
    send_sample(24'sd1000000, 16'd1);
    // bit 15 of the data falls outside the register
    write_reg(CFG_BASE_FREQ, 16'hFFFF);
    send_sample(24'sd123456, 16'd8192);
    write_reg(CFG_BASE_FREQ, 16'd20);
    send_sample(24'sd777777, 16'd8192);
  endtask

  task automatic test_resonance_clamp();
    write_reg(CFG_BASE_FREQ, 16'd2000);
    write_reg(CFG_RESONANCE, 16'hFFFF);
    send_sample(24'sd3000000, 16'd8192);
    send_sample(24'sd3000000, 16'd8192);
    write_reg(CFG_RESONANCE, 16'd64226);
    send_sample(-24'sd3000000, 16'd8192);
    write_reg(CFG_RESONANCE, 16'd64225);
    send_sample(-24'sd3000000, 16'd8192);
  endtask

  task automatic test_unused_register_index();
    write_reg(CFG_IDX_W'(2), 16'h1234);
    write_reg(CFG_IDX_W'(3), 16'hFFFF);
    send_sample(24'sd2000000, 16'd16384);
  endtask

  task automatic test_state_saturation();
    write_reg(CFG_BASE_FREQ, 16'd20000);
    write_reg(CFG_RESONANCE, 16'hFFFF);
    repeat (4) send_sample(24'sd8388607, 16'd65535);
    repeat (4) send_sample(-24'sd8388608, 16'd65535);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] base_pick;
    logic [CFG_DATA_W-1:0] res_pick;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] level;
    logic [RATIO_W-1:0] ratio;
    logic [RATIO_W-1:0] center;
    int kind;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 5))
        0: base_pick = 16'd20;
        1: base_pick = 16'd20000;
        2: base_pick = 16'd440;
        3: base_pick = 16'($urandom);
        4: base_pick = 16'd0;
        default: base_pick = 16'($urandom_range(20, 20000));
      endcase
      case ($urandom_range(0, 3))
        0: res_pick = 16'd0;
        1: res_pick = 16'hFFFF;
        2: res_pick = 16'd64225;
        default: res_pick = 16'($urandom);
      endcase
      if (p == 0) base_pick = 16'd20;
      if (p == 1) base_pick = 16'd20000;
      write_reg(CFG_BASE_FREQ, base_pick);
      write_reg(CFG_RESONANCE, res_pick);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 3)), 16'($urandom));
      rush = (p == 3) || (p == 7);
      center = 16'($urandom);
      level = 24'sd4000000;
      for (int i = 0; i < 200; i++) begin
        if (i % 25 == 0) level = -level;
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3: x = 24'($urandom);
          4, 5: x = 24'($signed($urandom_range(0, 8192)) - 4096);
          6: x = $urandom_range(0, 1) ? 24'sd8388607 : -24'sd8388608;
          default: x = level;
        endcase
        if ($urandom_range(0, 1)) ratio = 16'($urandom);
        else ratio = center ^ 16'($urandom_range(0, 255));
        send_sample(x, ratio);
      end
      rush = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_cutoff_clamps();
    test_resonance_clamp();
    test_unused_register_index();
    test_state_saturation();
    test_random_settings();
    settle();
    $display("Run covered %0d samples and %0d results over %0d register writes,",
             in_count, out_count, cfg_writes);
    $display("including cutoff and resonance clamps, saturation and unused indexes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/svf_pkg.sv
rtl/core/svf_datapath.sv
rtl/core/svf_ctrl.sv
rtl/core/resonant_svf_lowpass_core.sv
rtl/core/svf_checker.sv
test/resonant_svf_lowpass_core_tb.sv
